[rtl/core/json_string_escaper_unit_defines.svh]
// ---------------------------------------------------------------------------
// JSON string escaper - assertion macros
// Shared property templates for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_UNIT_DEFINES_SVH
`define JSON_STRING_ESCAPER_UNIT_DEFINES_SVH

// same-cycle implication, reset-gated
`define JSE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset-gated
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/jse_pkg.sv]
// ---------------------------------------------------------------------------
// JSON string escaper - package
// Types, constants and character expansion functions.
// ---------------------------------------------------------------------------
package jse_pkg;

	localparam int CP_W  = 21;
	localparam int IDX_W = 4;

	typedef logic [CP_W-1:0]  cp_t;
	typedef logic [IDX_W-1:0] cidx_t;
	typedef logic [6:0]       achar_t;

	localparam cp_t REPL_CP   = 21'h00FFFD;
	localparam cp_t PRINT_LO  = 21'h000020;
	localparam cp_t PRINT_HI  = 21'h00007E;
	localparam cp_t BMP_MAX   = 21'h00FFFF;
	localparam cp_t SUPP_BASE = 21'h010000;
	localparam cp_t SURR_LO   = 21'h00D800;
	localparam cp_t SURR_HI   = 21'h00DFFF;
	localparam cp_t CP_MAX    = 21'h10FFFF;
	localparam cp_t MIN_2B    = 21'h000080;
	localparam cp_t MIN_3B    = 21'h000800;
	localparam cp_t MIN_4B    = 21'h010000;

	localparam cp_t CP_QUOTE  = 21'h000022;
	localparam cp_t CP_BSLASH = 21'h00005C;
	localparam cp_t CP_BS     = 21'h000008;
	localparam cp_t CP_FF     = 21'h00000C;
	localparam cp_t CP_LF     = 21'h00000A;
	localparam cp_t CP_CR     = 21'h00000D;
	localparam cp_t CP_TAB    = 21'h000009;

	localparam achar_t CH_NONE   = 7'h00;
	localparam achar_t CH_QUOTE  = 7'h22;
	localparam achar_t CH_BSLASH = 7'h5C;
	localparam achar_t CH_B      = 7'h62;
	localparam achar_t CH_F      = 7'h66;
	localparam achar_t CH_N      = 7'h6E;
	localparam achar_t CH_R      = 7'h72;
	localparam achar_t CH_T      = 7'h74;
	localparam achar_t CH_U      = 7'h75;
	localparam achar_t CH_ZERO   = 7'h30;
	localparam achar_t CH_HEXA   = 7'h37;

	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;

	// one decoded request: opening quote, up to two code points, closing quote
	typedef struct packed {
		logic open;
		logic a_vld;
		cp_t  a_cp;
		logic b_vld;
		cp_t  b_cp;
		logic close;
	} jse_entry_t;

	function automatic achar_t esc_char(cp_t cp);
		achar_t r;
		case (cp)
			CP_QUOTE:  r = CH_QUOTE;
			CP_BSLASH: r = CH_BSLASH;
			CP_BS:     r = CH_B;
			CP_FF:     r = CH_F;
			CP_LF:     r = CH_N;
			CP_CR:     r = CH_R;
			CP_TAB:    r = CH_T;
			default:   r = CH_NONE;
		endcase
		return r;
	endfunction

	function automatic achar_t hex_char(logic [3:0] n);
		return (n < 4'd10) ? (CH_ZERO + {3'b000, n}) : (CH_HEXA + {3'b000, n});
	endfunction

	function automatic cidx_t cp_len(cp_t cp);
		if (esc_char(cp) != CH_NONE)
			return cidx_t'(2);
		else if (cp >= PRINT_LO && cp <= PRINT_HI)
			return cidx_t'(1);
		else if (cp > BMP_MAX)
			return cidx_t'(12);
		else
			return cidx_t'(6);
	endfunction

	function automatic achar_t cp_char(cp_t cp, cidx_t k);
		achar_t      e;
		cp_t         d;
		logic [15:0] unit;
		cidx_t       j;
		logic [3:0]  nib;
		e = esc_char(cp);
		d = cp - SUPP_BASE;
		if (cp > BMP_MAX) begin
			if (k < cidx_t'(6)) begin
				unit = {HI_SURR_TAG, d[19:10]};
				j    = k;
			end else begin
				unit = {LO_SURR_TAG, d[9:0]};
				j    = k - cidx_t'(6);
			end
		end else begin
			unit = cp[15:0];
			j    = k;
		end
		case (j)
			cidx_t'(2): nib = unit[15:12];
			cidx_t'(3): nib = unit[11:8];
			cidx_t'(4): nib = unit[7:4];
			default:    nib = unit[3:0];
		endcase
		if (e != CH_NONE)
			return (k == '0) ? CH_BSLASH : e;
		else if (cp >= PRINT_LO && cp <= PRINT_HI)
			return cp[6:0];
		else if (j == '0)
			return CH_BSLASH;
		else if (j == cidx_t'(1))
			return CH_U;
		else
			return hex_char(nib);
	endfunction

endpackage

[rtl/core/jse_fifo.sv]
// ---------------------------------------------------------------------------
// JSON string escaper - decoupling queue
// Small register queue between the decoder and the serializer.
// ---------------------------------------------------------------------------
module jse_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jse_pkg::jse_entry_t wdata,
	output logic                full,
	input  logic                pop,
	output jse_pkg::jse_entry_t rdata,
	output logic                empty
);
	import jse_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jse_entry_t    mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/jse_front.sv]
// ---------------------------------------------------------------------------
// JSON string escaper - UTF-8 decoder front end
// Accepts one byte per request, tracks the pending sequence and queues
// the quotes and code points that the request produces.
// ---------------------------------------------------------------------------
module jse_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [7:0]          str_byte,
	input  logic                byte_valid,
	input  logic                starts_string,
	input  logic                ends_string,
	output logic                push,
	output jse_pkg::jse_entry_t entry,
	input  logic                full
);
	import jse_pkg::*;

	cp_t        part_q;
	logic [1:0] rem_q;
	logic [2:0] len_q;

	cp_t        part_d;
	logic [1:0] rem_d;
	logic [2:0] len_d;

	always_comb begin
		cp_t  acc;
		cp_t  lo_min;
		logic bad;
		logic lead_now;

		entry       = '0;
		entry.open  = starts_string;
		entry.close = ends_string;
		part_d      = starts_string ? '0 : part_q;
		rem_d       = starts_string ? '0 : rem_q;
		len_d       = starts_string ? '0 : len_q;
		lead_now    = 1'b0;
		acc         = {part_d[14:0], str_byte[5:0]};
		lo_min      = (len_d == 3'd2) ? MIN_2B : (len_d == 3'd3) ? MIN_3B : MIN_4B;
		bad         = (acc < lo_min) || (acc >= SURR_LO && acc <= SURR_HI) || (acc > CP_MAX);

		if (byte_valid) begin
			if (rem_d == '0) begin
				lead_now = 1'b1;
			end else if (str_byte[7:6] != 2'b10) begin
				// broken continuation: replace and retry byte as a lead
				entry.a_vld = 1'b1;
				entry.a_cp  = REPL_CP;
				part_d      = '0;
				rem_d       = '0;
				len_d       = '0;
				lead_now    = 1'b1;
			end else begin
				part_d = acc;
				rem_d  = rem_d - 2'd1;
				if (rem_d == '0) begin
					entry.a_vld = 1'b1;
					entry.a_cp  = bad ? REPL_CP : acc;
					part_d      = '0;
					len_d       = '0;
				end
			end
		end

		if (lead_now) begin
			if (!str_byte[7]) begin
				entry.b_vld = 1'b1;
				entry.b_cp  = {13'b0, str_byte};
			end else if (str_byte[7:6] == 2'b10 || str_byte[7:3] == 5'b11111) begin
				entry.b_vld = 1'b1;
				entry.b_cp  = REPL_CP;
			end else if (str_byte[7:5] == 3'b110) begin
				part_d = {16'b0, str_byte[4:0]};
				rem_d  = 2'd1;
				len_d  = 3'd2;
			end else if (str_byte[7:4] == 4'b1110) begin
				part_d = {17'b0, str_byte[3:0]};
				rem_d  = 2'd2;
				len_d  = 3'd3;
			end else begin
				part_d = {18'b0, str_byte[2:0]};
				rem_d  = 2'd3;
				len_d  = 3'd4;
			end
		end

		if (ends_string) begin
			// cut-off sequence at end of string
			if (rem_d != '0) begin
				entry.b_vld = 1'b1;
				entry.b_cp  = REPL_CP;
			end
			part_d = '0;
			rem_d  = '0;
			len_d  = '0;
		end
	end

	assign req_ready = !full;
	assign push      = req_valid && !full &&
		(entry.open || entry.a_vld || entry.b_vld || entry.close);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			rem_q  <= '0;
			len_q  <= '0;
		end else if (req_valid && req_ready) begin
			part_q <= part_d;
			rem_q  <= rem_d;
			len_q  <= len_d;
		end
	end

endmodule

[rtl/core/jse_back.sv]
// ---------------------------------------------------------------------------
// JSON string escaper - character serializer back end
// Expands the queue head into escaped ASCII, one character per cycle
// while char_ready does not stall the output, into an output register.
// ---------------------------------------------------------------------------
module jse_back (
	input  logic                clk,
	input  logic                arst_n,
	input  jse_pkg::jse_entry_t head,
	input  logic                empty,
	output logic                pop,
	output logic                char_valid,
	input  logic                char_ready,
	output logic [6:0]          out_char,
	output logic                last_out
);
	import jse_pkg::*;

	localparam logic [1:0] SLOT_OPEN  = 2'd0;
	localparam logic [1:0] SLOT_A     = 2'd1;
	localparam logic [1:0] SLOT_B     = 2'd2;
	localparam logic [1:0] SLOT_CLOSE = 2'd3;

	logic [3:0] done_q;
	cidx_t      k_q;
	logic       out_valid_q;
	achar_t     out_char_q;
	logic       last_q;

	logic [3:0] vmask;
	logic [3:0] rem;
	logic [3:0] cur_oh;
	logic [1:0] cur;
	cp_t        cur_cp;
	logic       is_quote;
	cidx_t      slen;
	achar_t     ch;
	logic       slot_end;
	logic       entry_end;
	logic       adv;
	logic       take;

	assign vmask = {head.close, head.b_vld, head.a_vld, head.open};
	assign rem   = vmask & ~done_q;

	always_comb begin
		if (rem[0])      cur = SLOT_OPEN;
		else if (rem[1]) cur = SLOT_A;
		else if (rem[2]) cur = SLOT_B;
		else             cur = SLOT_CLOSE;
	end

	assign cur_oh    = 4'b0001 << cur;
	assign cur_cp    = (cur == SLOT_A) ? head.a_cp : head.b_cp;
	assign is_quote  = (cur == SLOT_OPEN) || (cur == SLOT_CLOSE);
	assign slen      = is_quote ? cidx_t'(1) : cp_len(cur_cp);
	assign ch        = is_quote ? CH_QUOTE : cp_char(cur_cp, k_q);
	assign slot_end  = (k_q == slen - cidx_t'(1));
	assign entry_end = slot_end && ((rem & ~cur_oh) == '0);
	assign adv       = !out_valid_q || char_ready;
	assign take      = adv && !empty;
	assign pop       = take && entry_end;

	assign char_valid = out_valid_q;
	assign out_char   = out_char_q;
	assign last_out   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
			k_q         <= '0;
		end else if (take) begin
			out_valid_q <= 1'b1;
			if (slot_end) begin
				k_q    <= '0;
				done_q <= entry_end ? '0 : (done_q | cur_oh);
			end else begin
				k_q <= k_q + cidx_t'(1);
			end
		end else if (adv) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_char_q <= ch;
			last_q     <= entry_end;
		end
	end

endmodule

[rtl/core/json_string_escaper_unit.sv]
// ---------------------------------------------------------------------------
// JSON string escaper unit
// UTF-8 bytes in, quoted and escaped ASCII JSON text out.
// ---------------------------------------------------------------------------
// Each request carries at most one UTF-8 byte plus start/end flags and is
// accepted while req_ready is high; the decoder turns it into an entry of
// quotes and up to two code points, held in a FIFO_DEPTH-entry queue. The
// serializer emits one character per cycle unless char_ready stalls it; a
// request yields up to 13 characters, and requests that yield nothing
// (continuation bytes mid-sequence) take no output slot. Printable text runs
// at one byte per cycle without stalls; req_ready drops while the queue is
// full, which happens behind escapes and \uXXXX expansions. A request passes
// through the queue and the output register before its first character.
module json_string_escaper_unit #(
	parameter int FIFO_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [7:0] str_byte,
	input  logic       byte_valid,
	input  logic       starts_string,
	input  logic       ends_string,
	output logic       char_valid,
	input  logic       char_ready,
	output logic [6:0] out_char,
	output logic       last_out
);
	import jse_pkg::*;

	jse_entry_t wr_entry;
	jse_entry_t head;
	logic       push;
	logic       full;
	logic       pop;
	logic       empty;

	jse_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.str_byte      (str_byte),
		.byte_valid    (byte_valid),
		.starts_string (starts_string),
		.ends_string   (ends_string),
		.push          (push),
		.entry         (wr_entry),
		.full          (full)
	);

	jse_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_entry),
		.full   (full),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty)
	);

	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.out_char   (out_char),
		.last_out   (last_out)
	);

endmodule

[rtl/core/jse_checker.sv]
// ---------------------------------------------------------------------------
// JSON string escaper - port checker
// Port-level properties of the escaper, bound to the top level.
// ---------------------------------------------------------------------------
`include "json_string_escaper_unit_defines.svh"

module jse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [7:0] str_byte,
	input logic       byte_valid,
	input logic       starts_string,
	input logic       ends_string,
	input logic       char_valid,
	input logic       char_ready,
	input logic [6:0] out_char,
	input logic       last_out
);

	`JSE_ASSERT_NEXT(a_out_hold, char_valid && !char_ready, char_valid && $stable(out_char) && $stable(last_out), "output changed while stalled")
	`JSE_ASSERT_SAME(a_char_printable, char_valid, (out_char >= 7'h20) && (out_char <= 7'h7E), "non-printable character emitted")
	`JSE_ASSERT_SAME(a_out_known, char_valid, !$isunknown({out_char, last_out}), "unknown output character")
	`JSE_ASSERT_NEXT(a_no_gap, char_valid && char_ready && !last_out, char_valid, "gap inside one request's characters")

endmodule

bind json_string_escaper_unit jse_checker u_jse_checker (.*);
